// File: src/gfmf_pkg.sv
package gfmf_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int ANGLE_BITS = 32;
  localparam int STEP_W = $clog2(CORDIC_STEPS);

  // CORDIC datapath widths: x/y in Q30 with headroom, z in turns with headroom.
  localparam int XW = 34;
  localparam int ZW = ANGLE_BITS + 2;
  localparam int FRAC = 30;
  localparam int MW = 32;

  localparam logic signed [XW-1:0] K_Q30 = XW'(652032874);
  localparam logic [FRAC:0] ONE_Q30 = 31'h4000_0000;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(1) << (ANGLE_BITS - 2);
  localparam logic signed [ZW-1:0] HALF = ZW'(1) << (ANGLE_BITS - 1);

  // Degree conversion of the raw ddmm.mmmm field.
  localparam int RAW_W = 28;
  localparam logic [28:0] RECIP_1E6 = 29'd281474977;
  localparam int RECIP_SHIFT = 48;
  localparam logic [18:0] MIN_CORR = 19'd400000;
  localparam logic [27:0] DEG_DEN = 28'd216000000;

  // Square root radicands reach 2^60.
  localparam int SQ_W = 62;
  localparam int ROOT_W = SQ_W / 2;

  // Distance scaling: z * C / 2^(ANGLE_BITS+20), C split into two partial products.
  localparam int C_W = 57;
  localparam int C_LO_W = 29;
  localparam int PROD_W = ANGLE_BITS + C_W;
  localparam int DIST_W = 36;

  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;

  function automatic logic [63:0] dist_const();
    logic [127:0] p;
    p = 128'd25484000000 * 128'h3243F6A8885A308D;
    return p[103:40];
  endfunction

  localparam logic [63:0] DIST_C = dist_const();
  localparam logic [C_LO_W-1:0] C_LO = DIST_C[C_LO_W-1:0];
  localparam logic [C_W-C_LO_W-1:0] C_HI = DIST_C[C_W-1:C_LO_W];

  // Arc tangent of 2^-i as a fraction of a turn; evaluated at elaboration only.
  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] pw;
    logic [63:0] dr;
    logic [63:0] dv;
    logic [63:0] rem;
    logic [63:0] q;
    logic carry;
    int e;
    sum = '0;
    if (i == 0) return ZW'(64'd1 << (ANGLE_BITS - 3));
    for (int k = 0; k < 32; k++) begin
      e = 61 - i * (2 * k + 1);
      if (e >= 0) begin
        pw = 64'd1 << e;
        dv = 64'(2 * k + 1);
        term = '0;
        dr = '0;
        for (int b = 63; b >= 0; b--) begin
          dr = {dr[62:0], pw[b]};
          if (dr >= dv) begin
            dr = dr - dv;
            term[b] = 1'b1;
          end
        end
        if ((k & 1) == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    rem = sum;
    q = '0;
    for (int b = 0; b <= ANGLE_BITS; b++) begin
      carry = rem[63];
      rem = rem << 1;
      q = q << 1;
      if (carry || rem >= PI_Q62) begin
        rem = rem - PI_Q62;
        q[0] = 1'b1;
      end
    end
    return ZW'((q + 64'd1) >> 1);
  endfunction

  typedef struct packed {
    logic vld;
    logic vec;
    logic neg;
    logic [1:0] tag;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cell_t;

  localparam logic [1:0] TAG_DLAT = 2'd0;
  localparam logic [1:0] TAG_DLON = 2'd1;
  localparam logic [1:0] TAG_LAT1 = 2'd2;
  localparam logic [1:0] TAG_LAT2 = 2'd3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_FIX = 1'b1;

  localparam logic [1:0] VERDICT_DROP = 2'd0;
  localparam logic [1:0] VERDICT_KEEP = 2'd1;
  localparam logic [1:0] VERDICT_STOP = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_SC_FEED,
    ST_SC_WAIT,
    ST_MUL,
    ST_SQRT,
    ST_VEC_FEED,
    ST_VEC_WAIT,
    ST_DIST,
    ST_DONE
  } state_t;

endpackage

// File: src/gfmf_cordic_cell.sv
module gfmf_cordic_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [gfmf_pkg::STEP_W-1:0]         step,
  input  logic signed [gfmf_pkg::ZW-1:0]      atan,
  input  gfmf_pkg::cell_t                     cell_in,
  output gfmf_pkg::cell_t                     cell_out
);
  import gfmf_pkg::*;

  cell_t cell_r;
  cell_t cell_nxt;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic dir;

  always_comb begin
    xs = cell_in.x >>> step;
    ys = cell_in.y >>> step;
    // Rotation drives z toward zero, vectoring drives y toward zero.
    dir = cell_in.vec ? cell_in.y[XW-1] : ~cell_in.z[ZW-1];
    cell_nxt = cell_in;
    if (dir) begin
      cell_nxt.x = cell_in.x - ys;
      cell_nxt.y = cell_in.y + xs;
      cell_nxt.z = cell_in.z - atan;
    end else begin
      cell_nxt.x = cell_in.x + ys;
      cell_nxt.y = cell_in.y - xs;
      cell_nxt.z = cell_in.z + atan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cell_r <= '0;
    else cell_r <= cell_nxt;
  end

  assign cell_out = cell_r;

endmodule

// File: src/gfmf_turns.sv
module gfmf_turns (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [gfmf_pkg::RAW_W-1:0]          raw,
  output logic                                done,
  output logic [gfmf_pkg::ANGLE_BITS-1:0]     turns
);
  import gfmf_pkg::*;

  localparam int CNT_W = $clog2(ANGLE_BITS + 3);

  logic busy_r;
  logic done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [RAW_W-1:0] raw_r;
  logic [8:0] deg_r;
  logic [27:0] rem_r;
  logic [ANGLE_BITS-1:0] res_r;
  logic [56:0] recip_prod;
  logic [28:0] rem_sh;
  logic bit_set;

  always_comb begin
    recip_prod = 57'(raw_r) * 57'(RECIP_1E6);
    rem_sh = {rem_r, 1'b0};
    bit_set = rem_sh >= 29'(DEG_DEN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= '0;
      raw_r <= raw;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == '0) begin
        deg_r <= recip_prod[RECIP_SHIFT+8:RECIP_SHIFT];
      end else if (cnt_r == CNT_W'(1)) begin
        // Minutes kept as they are: q = raw - degrees * 400000.
        rem_r <= raw_r - 28'(deg_r) * 28'(MIN_CORR);
      end else begin
        rem_r <= bit_set ? 28'(rem_sh - 29'(DEG_DEN)) : rem_sh[27:0];
        res_r <= {res_r[ANGLE_BITS-2:0], bit_set};
        if (cnt_r == CNT_W'(ANGLE_BITS + 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else done_r <= !start && busy_r && (cnt_r == CNT_W'(ANGLE_BITS + 1));
  end

  assign done = done_r;
  assign turns = res_r;

endmodule

// File: src/gfmf_isqrt.sv
module gfmf_isqrt (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [gfmf_pkg::SQ_W-1:0]           radicand,
  output logic                                done,
  output logic [gfmf_pkg::ROOT_W-1:0]         root
);
  import gfmf_pkg::*;

  logic busy_r;
  logic done_r;
  logic [SQ_W-1:0] v_r;
  logic [SQ_W-1:0] r_r;
  logic [SQ_W-1:0] bit_r;
  logic [SQ_W-1:0] trial;
  logic fits;

  always_comb begin
    trial = r_r + bit_r;
    fits = v_r >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      v_r <= radicand;
      r_r <= '0;
      bit_r <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_r) begin
      if (fits) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
      if (bit_r == SQ_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else done_r <= !start && busy_r && (bit_r == SQ_W'(1));
  end

  assign done = done_r;
  assign root = r_r[ROOT_W-1:0];

endmodule

// File: src/gps_fix_movement_filter_core.sv
// GPS fix movement filter. Each input transaction carries one fix (NMEA ddmm.mmmm
// times 10^4); a start fix only becomes the reference, a following fix is compared
// with the reference by haversine distance in millimetres and reported as dropped,
// kept or as a stop report, with exactly one output transaction per input. One fix
// is processed at a time. A following fix passes through the bit-serial degree
// conversion, the two serial square-root units and two passes through the 28-cell
// CORDIC chain; a start fix only through the degree conversion. The next fix is
// taken while a finished result still waits on the output.
// Configuration writes must only happen while the block is idle.
module gps_fix_movement_filter_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_op,
  input  logic [26:0]                             in_latitude_raw,
  input  logic [27:0]                             in_longitude_raw,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [1:0]                              out_verdict,
  output logic [34:0]                             out_distance_mm,
  input  logic                                    cfg_we,
  input  logic [gfmf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [19:0]                             cfg_wdata
);
  import gfmf_pkg::*;

  state_t state_r, state_nxt;
  logic [2:0] step_r;
  logic op_r;
  logic [ANGLE_BITS-1:0] plat_r, plon_r;
  logic [7:0] still_r, still_nxt;
  logic [19:0] thr_r;
  logic [7:0] stop_r;

  logic lat_done, lon_done;
  logic [ANGLE_BITS-1:0] lat_t, lon_t;
  logic in_acc;

  cell_t feed_r, feed_c;
  cell_t chain [CORDIC_STEPS+1];
  cell_t cout;
  logic signed [XW-1:0] sval, cval;
  logic signed [MW-1:0] s1_r, s2_r, c1_r, c2_r;
  logic [2:0] rx_cnt_r;
  logic signed [ZW-1:0] z_r;
  logic z_done_r;

  logic signed [MW-1:0] ma, mb, prod_sh, t_s1_r, t_cc_r;
  logic signed [2*MW-1:0] prod_r;
  logic signed [MW:0] asum;
  logic [FRAC:0] a_r, a_nxt;

  logic sq_start, sqx_done, sqy_done;
  logic [ROOT_W-1:0] root_x, root_y;

  logic [ANGLE_BITS-1:0] zu;
  logic [C_LO_W-1:0] dm_b;
  logic [ANGLE_BITS+C_LO_W-1:0] dmul, dprod_lo_r, dprod_hi_r;
  logic [PROD_W-1:0] full, vsh;
  logic [DIST_W-1:0] dist_r, dist_c;

  logic signed [ANGLE_BITS:0] dlat, dlon;
  logic [7:0] cnt1;
  logic [1:0] verdict_nxt;
  logic out_load;
  logic out_valid_r;
  logic [1:0] out_verdict_r;
  logic [34:0] out_dist_r;

  function automatic cell_t make_rot(input logic signed [ANGLE_BITS-1:0] ang,
                                     input logic [1:0] tag);
    cell_t c;
    logic signed [ZW-1:0] zw;
    zw = ZW'(ang);
    c = '0;
    c.vld = 1'b1;
    c.tag = tag;
    c.x = K_Q30;
    // Fold into the quarter turn on either side of zero; the result is negated.
    if (zw > QUARTER) begin
      c.z = zw - HALF;
      c.neg = 1'b1;
    end else if (zw < -QUARTER) begin
      c.z = zw + HALF;
      c.neg = 1'b1;
    end else begin
      c.z = zw;
    end
    return c;
  endfunction

  assign in_acc = in_valid && in_ready;

  gfmf_turns u_lat_turns (
    .clk(clk), .rst_n(rst_n), .start(in_acc),
    .raw({1'b0, in_latitude_raw}), .done(lat_done), .turns(lat_t)
  );

  gfmf_turns u_lon_turns (
    .clk(clk), .rst_n(rst_n), .start(in_acc),
    .raw(in_longitude_raw), .done(lon_done), .turns(lon_t)
  );

  gfmf_isqrt u_sqrt_x (
    .clk(clk), .rst_n(rst_n), .start(sq_start),
    .radicand(SQ_W'(ONE_Q30 - a_r) << FRAC), .done(sqx_done), .root(root_x)
  );

  gfmf_isqrt u_sqrt_y (
    .clk(clk), .rst_n(rst_n), .start(sq_start),
    .radicand(SQ_W'(a_r) << FRAC), .done(sqy_done), .root(root_y)
  );

  assign chain[0] = feed_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    gfmf_cordic_cell u_cell (
      .clk(clk), .rst_n(rst_n), .step(STEP_W'(i)), .atan(atan_entry(i)),
      .cell_in(chain[i]), .cell_out(chain[i+1])
    );
  end

  assign cout = chain[CORDIC_STEPS];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_CONV;
      ST_CONV:     if (lat_done && lon_done)
                     state_nxt = (op_r == OP_START) ? ST_DONE : ST_SC_FEED;
      ST_SC_FEED:  if (step_r == 3'd3) state_nxt = ST_SC_WAIT;
      ST_SC_WAIT:  if (rx_cnt_r == 3'd4) state_nxt = ST_MUL;
      ST_MUL:      if (step_r == 3'd4) state_nxt = ST_SQRT;
      ST_SQRT:     if (sqx_done && sqy_done) state_nxt = ST_VEC_FEED;
      ST_VEC_FEED: state_nxt = ST_VEC_WAIT;
      ST_VEC_WAIT: if (z_done_r) state_nxt = ST_DIST;
      ST_DIST:     if (step_r == 3'd2) state_nxt = ST_DONE;
      ST_DONE:     if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    dlat = $signed({1'b0, lat_t}) - $signed({1'b0, plat_r});
    dlon = $signed({1'b0, lon_t}) - $signed({1'b0, plon_r});
    in_ready = 1'b0;
    sq_start = 1'b0;
    out_load = 1'b0;
    feed_c = '0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SC_FEED: begin
        case (step_r)
          3'd0: feed_c = make_rot(ANGLE_BITS'(dlat >>> 1), TAG_DLAT);
          3'd1: feed_c = make_rot(ANGLE_BITS'(dlon >>> 1), TAG_DLON);
          3'd2: feed_c = make_rot(plat_r, TAG_LAT1);
          3'd3: feed_c = make_rot(lat_t, TAG_LAT2);
          default: feed_c = '0;
        endcase
      end
      ST_SQRT: sq_start = (step_r == 3'd0);
      ST_VEC_FEED: begin
        feed_c.vld = 1'b1;
        feed_c.vec = 1'b1;
        feed_c.x = XW'(root_x);
        feed_c.y = XW'(root_y);
      end
      ST_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Shared multiplier for the haversine term.
  always_comb begin
    prod_sh = MW'(prod_r >>> FRAC);
    case (step_r)
      3'd0: begin ma = s1_r; mb = s1_r; end
      3'd1: begin ma = c1_r; mb = c2_r; end
      3'd2: begin ma = s2_r; mb = s2_r; end
      3'd3: begin ma = t_cc_r; mb = prod_sh; end
      default: begin ma = '0; mb = '0; end
    endcase
    asum = (MW+1)'(t_s1_r) + (MW+1)'(prod_sh);
    if (asum < 0) a_nxt = '0;
    else if (asum > $signed((MW+1)'(ONE_Q30))) a_nxt = ONE_Q30;
    else a_nxt = asum[FRAC:0];
  end

  always_comb begin
    sval = cout.neg ? -cout.y : cout.y;
    cval = cout.neg ? -cout.x : cout.x;
    zu = z_r[ZW-1] ? '0 : z_r[ANGLE_BITS-1:0];
    dm_b = (step_r == 3'd0) ? C_LO : C_LO_W'(C_HI);
    dmul = (ANGLE_BITS+C_LO_W)'(zu) * (ANGLE_BITS+C_LO_W)'(dm_b);
    full = (PROD_W'(dprod_hi_r) << C_LO_W) + PROD_W'(dprod_lo_r);
    vsh = full >> (ANGLE_BITS + 19);
    dist_c = DIST_W'((vsh + PROD_W'(1)) >> 1);
  end

  // Decision on the finished fix.
  always_comb begin
    cnt1 = still_r + 8'd1;
    still_nxt = still_r;
    verdict_nxt = VERDICT_KEEP;
    if (op_r == OP_FIX) begin
      if (dist_r > DIST_W'(thr_r)) begin
        still_nxt = '0;
      end else if (cnt1 == stop_r) begin
        verdict_nxt = VERDICT_STOP;
        still_nxt = '0;
      end else begin
        verdict_nxt = VERDICT_DROP;
        still_nxt = cnt1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= '0;
      feed_r.vld <= 1'b0;
      plat_r <= '0;
      plon_r <= '0;
      still_r <= '0;
      thr_r <= 20'd3000;
      stop_r <= 8'd60;
      rx_cnt_r <= '0;
      z_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // The step counter holds at its top value, so a long wait never sees a
      // second first step.
      step_r <= (state_nxt != state_r) ? 3'd0 :
                ((step_r == 3'd7) ? step_r : step_r + 3'd1);
      feed_r <= feed_c;

      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD: thr_r <= cfg_wdata;
          CFG_STOP:      stop_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        op_r <= in_op;
        rx_cnt_r <= '0;
        z_done_r <= 1'b0;
      end

      if (cout.vld) begin
        if (cout.vec) begin
          z_r <= cout.z;
          z_done_r <= 1'b1;
        end else begin
          rx_cnt_r <= rx_cnt_r + 3'd1;
          case (cout.tag)
            TAG_DLAT: s1_r <= MW'(sval);
            TAG_DLON: s2_r <= MW'(sval);
            TAG_LAT1: c1_r <= MW'(cval);
            TAG_LAT2: c2_r <= MW'(cval);
            default: ;
          endcase
        end
      end

      if (state_r == ST_MUL) begin
        prod_r <= (2*MW)'(ma) * (2*MW)'(mb);
        if (step_r == 3'd1) t_s1_r <= prod_sh;
        if (step_r == 3'd2) t_cc_r <= prod_sh;
        if (step_r == 3'd4) a_r <= a_nxt;
      end

      if (state_r == ST_DIST) begin
        if (step_r == 3'd0) dprod_lo_r <= dmul;
        if (step_r == 3'd1) dprod_hi_r <= dmul;
        if (step_r == 3'd2) dist_r <= dist_c;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        out_verdict_r <= verdict_nxt;
        out_dist_r <= (op_r == OP_FIX) ? dist_r[34:0] : '0;
        still_r <= still_nxt;
        plat_r <= lat_t;
        plon_r <= lon_t;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_verdict = out_verdict_r;
  assign out_distance_mm = out_dist_r;

endmodule

// File: src/gfmf_checker.sv
module gfmf_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [1:0]                           out_verdict,
  input logic [34:0]                          out_distance_mm
);
  import gfmf_pkg::*;

  // Only one fix is in flight, so the input closes right after a transaction.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a fix is in flight");

  // A fix is never finished as it is accepted, so an empty output stays empty the cycle after.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |=> !out_valid)
    else $error("result appeared too early");

  // A dropped fix or a stop report only comes from a distance within the threshold.
  a_still_within_threshold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_verdict == VERDICT_DROP || out_verdict == VERDICT_STOP))
      |-> (out_distance_mm < 35'h0010_0000))
    else $error("still fix with distance beyond any threshold");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_verdict) && $stable(out_distance_mm)))
    else $error("stalled result changed");

endmodule

bind gps_fix_movement_filter_core gfmf_checker u_gfmf_checker (.*);
